// ===== rtl/core/lpp_pkg.sv =====
// Package for the Lorentz particle push: payload structs and register indexes.
// Used by lorentz_particle_push; depends on nothing else.
package lpp_pkg;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic               end_of_batch;
   } in_type;

   typedef struct packed {
      logic signed [31:0] new_pos_x;
      logic signed [31:0] new_pos_y;
      logic signed [31:0] new_pos_z;
      logic signed [31:0] new_vel_x;
      logic signed [31:0] new_vel_y;
      logic signed [31:0] new_vel_z;
      logic               batch_end;
   } out_type;

   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_STEP_DT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_E_FIELD_X = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_E_FIELD_Y = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_E_FIELD_Z = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_B_FIELD_X = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_B_FIELD_Y = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_B_FIELD_Z = 3'd6;

endpackage

// ===== rtl/core/lpp_mul_rnd.sv =====
// Two-stage fixed-point multiplier: registered 32x32 signed product, then
// registered round-to-nearest (ties up) shift by FRAC_BITS. No dependencies.
module lpp_mul_rnd #(
   parameter int FRAC_BITS = 16
) (
   input  logic                           clock,
   input  logic signed [31:0]             a,
   input  logic signed [31:0]             b,
   output logic signed [63-FRAC_BITS:0]   rnd
);

   localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

   logic signed [63:0]           prod_ff;
   logic signed [63:0]           prod_in;
   logic signed [63:0]           biased;
   logic signed [63-FRAC_BITS:0] rnd_ff;
   logic signed [63-FRAC_BITS:0] rnd_in;

   assign prod_in = a * b;

   // The product lies within plus or minus 2^62, so adding one half cannot wrap.
   assign biased = prod_ff + HALF;
   assign rnd_in = biased[63:FRAC_BITS];

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      rnd_ff  <= rnd_in;
   end

   assign rnd = rnd_ff;

endmodule

// ===== rtl/core/lorentz_particle_push.sv =====
// Top level of the Lorentz particle push: APB-style register file and the
// seven-stage push pipeline. Depends on lpp_pkg and lpp_mul_rnd.

// One particle goes in per transfer and one advanced particle comes out, and
// the block takes a new particle in every clock cycle: busy never rises. The
// result leaves the output register and is shown for exactly one cycle
// with rsp_strobe high, in the order the particles went in. The receiver
// cannot stall the block, so it must take every result in the cycle it is
// shown. The pipeline is built from two multiply-and-round units in series: the
// force term v x B is formed first and then scaled by dt, each unit taking a
// product stage and a rounding stage, with a saturating add stage after each.
// The fields E, B and dt sit in seven 32-bit registers at byte addresses
// 0, 4, ... 24 in the order dt, Ex, Ey, Ez, Bx, By, Bz; they must only be
// written while no particle is in flight. All values are signed fixed point
// with FRAC_BITS fraction bits, and every sum saturates to 32 bits.
module lorentz_particle_push
   import lpp_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  in_type       req_data,
   output logic         rsp_strobe,
   output out_type      rsp_data,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [4:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   // Width of a rounded product and of the exact sums built from it.
   localparam int RW = 64 - FRAC_BITS;
   localparam int SW = RW + 2;
   localparam int DEPTH = 6;

   // Clamp an exact sum to the signed 32-bit range.
   function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
      logic hi_all;
      logic hi_none;
      hi_all  = &v[SW-1:31];
      hi_none = ~|v[SW-1:31];
      if (hi_all || hi_none) begin
         sat32 = v[31:0];
      end else if (v[SW-1]) begin
         sat32 = 32'sh8000_0000;
      end else begin
         sat32 = 32'sh7fff_ffff;
      end
   endfunction

   function automatic logic signed [SW-1:0] ext32(input logic signed [31:0] v);
      ext32 = {{(SW-32){v[31]}}, v};
   endfunction

   function automatic logic signed [SW-1:0] extr(input logic signed [RW-1:0] v);
      extr = {{(SW-RW){v[RW-1]}}, v};
   endfunction

   // ---------------------------------------------------------------------
   // Register file. A write lands on the access cycle; pready is always high.
   // ---------------------------------------------------------------------
   logic signed [31:0]    dt_ff, ex_ff, ey_ff, ez_ff, bx_ff, by_ff, bz_ff;
   logic [CSR_IDX_W-1:0]  csr_idx;
   logic                  csr_wr;

   assign pready  = 1'b1;
   assign csr_idx = paddr[4:2];
   assign csr_wr  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         dt_ff <= '0;
         ex_ff <= '0;
         ey_ff <= '0;
         ez_ff <= '0;
         bx_ff <= '0;
         by_ff <= '0;
         bz_ff <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            CSR_STEP_DT:   dt_ff <= pwdata;
            CSR_E_FIELD_X: ex_ff <= pwdata;
            CSR_E_FIELD_Y: ey_ff <= pwdata;
            CSR_E_FIELD_Z: ez_ff <= pwdata;
            CSR_B_FIELD_X: bx_ff <= pwdata;
            CSR_B_FIELD_Y: by_ff <= pwdata;
            CSR_B_FIELD_Z: bz_ff <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_STEP_DT:   prdata = dt_ff;
         CSR_E_FIELD_X: prdata = ex_ff;
         CSR_E_FIELD_Y: prdata = ey_ff;
         CSR_E_FIELD_Z: prdata = ez_ff;
         CSR_B_FIELD_X: prdata = bx_ff;
         CSR_B_FIELD_Y: prdata = by_ff;
         CSR_B_FIELD_Z: prdata = bz_ff;
         default:       prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Valid bits and the particle delay line. Entry 0 is the captured input;
   // later entries carry position and velocity to where they are added.
   // ---------------------------------------------------------------------
   assign busy = 1'b0;

   logic [DEPTH:0] valid_ff;
   logic [DEPTH:0] valid_in;
   in_type         data_ff [DEPTH];

   assign valid_in = {valid_ff[DEPTH-1:0], start};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff[0] <= req_data;
      for (int i = 1; i < DEPTH; i++) begin
         data_ff[i] <= data_ff[i-1];
      end
   end

   // ---------------------------------------------------------------------
   // Stages 2 and 3: cross products with B and dt times velocity.
   // ---------------------------------------------------------------------
   logic signed [RW-1:0] r_vy_bz, r_vz_by, r_vz_bx, r_vx_bz, r_vx_by, r_vy_bx;
   logic signed [RW-1:0] r_dt_vx, r_dt_vy, r_dt_vz;

   lpp_mul_rnd #(.FRAC_BITS(FRAC_BITS)) u_vy_bz (
      .clock(clock), .a(data_ff[0].vel_y), .b(bz_ff), .rnd(r_vy_bz));
   lpp_mul_rnd #(.FRAC_BITS(FRAC_BITS)) u_vz_by (
      .clock(clock), .a(data_ff[0].vel_z), .b(by_ff), .rnd(r_vz_by));
   lpp_mul_rnd #(.FRAC_BITS(FRAC_BITS)) u_vz_bx (
      .clock(clock), .a(data_ff[0].vel_z), .b(bx_ff), .rnd(r_vz_bx));
   lpp_mul_rnd #(.FRAC_BITS(FRAC_BITS)) u_vx_bz (
      .clock(clock), .a(data_ff[0].vel_x), .b(bz_ff), .rnd(r_vx_bz));
   lpp_mul_rnd #(.FRAC_BITS(FRAC_BITS)) u_vx_by (
      .clock(clock), .a(data_ff[0].vel_x), .b(by_ff), .rnd(r_vx_by));
   lpp_mul_rnd #(.FRAC_BITS(FRAC_BITS)) u_vy_bx (
      .clock(clock), .a(data_ff[0].vel_y), .b(bx_ff), .rnd(r_vy_bx));
   lpp_mul_rnd #(.FRAC_BITS(FRAC_BITS)) u_dt_vx (
      .clock(clock), .a(dt_ff), .b(data_ff[0].vel_x), .rnd(r_dt_vx));
   lpp_mul_rnd #(.FRAC_BITS(FRAC_BITS)) u_dt_vy (
      .clock(clock), .a(dt_ff), .b(data_ff[0].vel_y), .rnd(r_dt_vy));
   lpp_mul_rnd #(.FRAC_BITS(FRAC_BITS)) u_dt_vz (
      .clock(clock), .a(dt_ff), .b(data_ff[0].vel_z), .rnd(r_dt_vz));

   // ---------------------------------------------------------------------
   // Stage 4: force components E + v x B and the new position, each summed
   // exactly and then saturated. The force is clamped before scaling by dt.
   // ---------------------------------------------------------------------
   logic signed [31:0] fx_ff, fy_ff, fz_ff, fx_in, fy_in, fz_in;
   logic signed [31:0] npx_ff, npy_ff, npz_ff, npx_in, npy_in, npz_in;

   assign fx_in = sat32(ext32(ex_ff) + extr(r_vy_bz) - extr(r_vz_by));
   assign fy_in = sat32(ext32(ey_ff) + extr(r_vz_bx) - extr(r_vx_bz));
   assign fz_in = sat32(ext32(ez_ff) + extr(r_vx_by) - extr(r_vy_bx));

   assign npx_in = sat32(ext32(data_ff[2].pos_x) + extr(r_dt_vx));
   assign npy_in = sat32(ext32(data_ff[2].pos_y) + extr(r_dt_vy));
   assign npz_in = sat32(ext32(data_ff[2].pos_z) + extr(r_dt_vz));

   // The position goes on through two more registers to line up with the
   // velocity result.
   logic signed [31:0] npx_d_ff [2];
   logic signed [31:0] npy_d_ff [2];
   logic signed [31:0] npz_d_ff [2];

   always_ff @(posedge clock) begin
      fx_ff       <= fx_in;
      fy_ff       <= fy_in;
      fz_ff       <= fz_in;
      npx_ff      <= npx_in;
      npy_ff      <= npy_in;
      npz_ff      <= npz_in;
      npx_d_ff[0] <= npx_ff;
      npy_d_ff[0] <= npy_ff;
      npz_d_ff[0] <= npz_ff;
      npx_d_ff[1] <= npx_d_ff[0];
      npy_d_ff[1] <= npy_d_ff[0];
      npz_d_ff[1] <= npz_d_ff[0];
   end

   // ---------------------------------------------------------------------
   // Stages 5 and 6: dt times force.
   // ---------------------------------------------------------------------
   logic signed [RW-1:0] r_dt_fx, r_dt_fy, r_dt_fz;

   lpp_mul_rnd #(.FRAC_BITS(FRAC_BITS)) u_dt_fx (
      .clock(clock), .a(dt_ff), .b(fx_ff), .rnd(r_dt_fx));
   lpp_mul_rnd #(.FRAC_BITS(FRAC_BITS)) u_dt_fy (
      .clock(clock), .a(dt_ff), .b(fy_ff), .rnd(r_dt_fy));
   lpp_mul_rnd #(.FRAC_BITS(FRAC_BITS)) u_dt_fz (
      .clock(clock), .a(dt_ff), .b(fz_ff), .rnd(r_dt_fz));

   // ---------------------------------------------------------------------
   // Stage 7: new velocity from the old one and the output register.
   // ---------------------------------------------------------------------
   out_type out_ff;
   out_type out_in;

   always_comb begin
      out_in.new_pos_x = npx_d_ff[1];
      out_in.new_pos_y = npy_d_ff[1];
      out_in.new_pos_z = npz_d_ff[1];
      out_in.new_vel_x = sat32(ext32(data_ff[DEPTH-1].vel_x) + extr(r_dt_fx));
      out_in.new_vel_y = sat32(ext32(data_ff[DEPTH-1].vel_y) + extr(r_dt_fy));
      out_in.new_vel_z = sat32(ext32(data_ff[DEPTH-1].vel_z) + extr(r_dt_fz));
      out_in.batch_end = data_ff[DEPTH-1].end_of_batch;
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_strobe = valid_ff[DEPTH];
   assign rsp_data   = out_ff;

endmodule

// ===== test/lorentz_particle_push_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for lorentz_particle_push: APB field setup, particle
// stimulus and a scoreboard that predicts each pushed particle.
// Depends on lpp_pkg and the lorentz_particle_push RTL.
module lorentz_particle_push_test;
   import lpp_pkg::*;

   localparam int FRAC_BITS = 16;
   // The limit sits far above what the whole run needs, even with every
   // particle taking the longest sender gap, so this only catches a hang.
   localparam int CYCLE_LIMIT = 400000;
   localparam int PUSH_LATENCY = 7;

   // The scoreboard keeps its own copy of dt, E and B and predicts one
   // Euler step per particle. Expected particles wait in arrival order.
   class push_scoreboard;
      logic signed [31:0] field_reg [7];
      out_type            advanced_q [$];
      int unsigned        errors;

      function new();
         foreach (field_reg[i]) field_reg[i] = '0;
         errors = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] value);
         field_reg[idx] = value;
      endfunction

      // Exact 64-bit product, rounded to nearest with ties toward plus infinity.
      function longint rnd_mul(longint a, longint b);
         return (a * b + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
      endfunction

      function longint clamp32(longint v);
         if (v > longint'(32'sh7FFFFFFF)) return longint'(32'sh7FFFFFFF);
         if (v < -longint'(32'sh7FFFFFFF) - 1) return -longint'(32'sh7FFFFFFF) - 1;
         return v;
      endfunction

      function out_type push_particle(in_type p);
         longint dt, ex, ey, ez, bx, by, bz;
         longint vx, vy, vz, fx, fy, fz;
         out_type r;
         dt = field_reg[CSR_STEP_DT];
         ex = field_reg[CSR_E_FIELD_X];
         ey = field_reg[CSR_E_FIELD_Y];
         ez = field_reg[CSR_E_FIELD_Z];
         bx = field_reg[CSR_B_FIELD_X];
         by = field_reg[CSR_B_FIELD_Y];
         bz = field_reg[CSR_B_FIELD_Z];
         vx = p.vel_x;
         vy = p.vel_y;
         vz = p.vel_z;
         // The force is E + v x B, clamped to 32 bits before dt scales it.
         fx = clamp32(ex + rnd_mul(vy, bz) - rnd_mul(vz, by));
         fy = clamp32(ey + rnd_mul(vz, bx) - rnd_mul(vx, bz));
         fz = clamp32(ez + rnd_mul(vx, by) - rnd_mul(vy, bx));
         r.new_pos_x = 32'(clamp32(longint'(p.pos_x) + rnd_mul(dt, vx)));
         r.new_pos_y = 32'(clamp32(longint'(p.pos_y) + rnd_mul(dt, vy)));
         r.new_pos_z = 32'(clamp32(longint'(p.pos_z) + rnd_mul(dt, vz)));
         r.new_vel_x = 32'(clamp32(vx + rnd_mul(dt, fx)));
         r.new_vel_y = 32'(clamp32(vy + rnd_mul(dt, fy)));
         r.new_vel_z = 32'(clamp32(vz + rnd_mul(dt, fz)));
         r.batch_end = p.end_of_batch;
         return r;
      endfunction

      function void note_particle(in_type p);
         advanced_q.push_back(push_particle(p));
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_result(out_type got);
         out_type want;
         if (advanced_q.size() == 0) begin
            $display("%0t ns: unexpected result, expected none, actual %h", $time, got);
            errors++;
            return;
         end
         want = advanced_q.pop_front();
         compare_field("new_pos_x", want.new_pos_x, got.new_pos_x);
         compare_field("new_pos_y", want.new_pos_y, got.new_pos_y);
         compare_field("new_pos_z", want.new_pos_z, got.new_pos_z);
         compare_field("new_vel_x", want.new_vel_x, got.new_vel_x);
         compare_field("new_vel_y", want.new_vel_y, got.new_vel_y);
         compare_field("new_vel_z", want.new_vel_z, got.new_vel_z);
         compare_field("batch_end", 32'(want.batch_end), 32'(got.batch_end));
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   in_type      req_data;
   logic        rsp_strobe;
   out_type     rsp_data;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [4:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   push_scoreboard sb = new();

   // Largest sender gap for the current stretch of particles; zero gives a
   // back-to-back stretch with a transfer on every cycle.
   int unsigned gap_max;

   lorentz_particle_push #(
      .FRAC_BITS(FRAC_BITS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // The receiver cannot hold results off, so every strobe is checked at the
   // edge that ends its cycle. Values read here are the ones from before the
   // edge, since the block updates its outputs with nonblocking assignments.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         sb.check_result(rsp_data);
      end
   end

   // Watchdog: a hang anywhere ends the run as a failure.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("lorentz_particle_push regression: fail");
      $finish;
   end

   // One APB write: a setup cycle, then an access cycle that completes at the
   // edge where pready is seen high. The scoreboard copy follows the write.
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sb.set_reg(idx, value);
   endtask

   task automatic set_fields(logic [31:0] dt, logic [31:0] ex, logic [31:0] ey,
                             logic [31:0] ez, logic [31:0] bx, logic [31:0] by,
                             logic [31:0] bz);
      write_reg(CSR_STEP_DT, dt);
      write_reg(CSR_E_FIELD_X, ex);
      write_reg(CSR_E_FIELD_Y, ey);
      write_reg(CSR_E_FIELD_Z, ez);
      write_reg(CSR_B_FIELD_X, bx);
      write_reg(CSR_B_FIELD_Y, by);
      write_reg(CSR_B_FIELD_Z, bz);
   endtask

   // Offers one particle after a random gap and waits for its transfer. The
   // start line is left high after a transfer, so a particle that follows with
   // no gap sees a single assignment to start in that time step.
   task automatic send_particle(in_type p);
      int unsigned gap;
      gap = $urandom_range(0, gap_max);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= p;
      do @(posedge clock); while (busy);
      sb.note_particle(p);
   endtask

   // The sender stops until every pushed particle has come back, then waits on
   // past the push latency, so that the block is idle for register writes.
   task automatic drain_pushes();
      start <= 1'b0;
      while (sb.advanced_q.size() != 0) @(posedge clock);
      repeat (PUSH_LATENCY + 3) @(posedge clock);
   endtask

   function automatic in_type make_particle(logic [31:0] px, logic [31:0] py,
                                            logic [31:0] pz, logic [31:0] vx,
                                            logic [31:0] vy, logic [31:0] vz,
                                            logic eob);
      in_type p;
      p.pos_x = px;
      p.pos_y = py;
      p.pos_z = pz;
      p.vel_x = vx;
      p.vel_y = vy;
      p.vel_z = vz;
      p.end_of_batch = eob;
      return p;
   endfunction

   // A fixed-point value mixing full-range noise, values of a few units,
   // moderate values and the corner values that drive rounding and clamping.
   function automatic logic [31:0] rand_fx();
      case ($urandom_range(0, 6))
         0, 1: return $urandom();
         2: return 32'(int'($urandom_range(0, 32'h80000)) - 32'sh40000);
         3: return 32'(int'($urandom_range(0, 32'h2000000)) - 32'sh1000000);
         4: begin
            case ($urandom_range(0, 6))
               0: return 32'h7FFFFFFF;
               1: return 32'h80000000;
               2: return 32'h00000000;
               3: return 32'h00000001;
               4: return 32'hFFFFFFFF;
               5: return 32'h00008000;
               default: return 32'h00010000;
            endcase
         end
         default: return 32'(int'($urandom_range(0, 32'h10000000)) - 32'sh8000000);
      endcase
   endfunction

   function automatic in_type rand_particle();
      return make_particle(rand_fx(), rand_fx(), rand_fx(), rand_fx(), rand_fx(),
                           rand_fx(), ($urandom_range(0, 7) == 0));
   endfunction

   initial begin
      int unsigned phase;
      int unsigned n;

      reset   <= 1'b1;
      start   <= 1'b0;
      req_data <= '0;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= '0;
      pwdata  <= '0;
      gap_max = 14;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // With the reset fields (all zero) every particle must come back as it
      // went in.
      for (n = 0; n < 40; n++) send_particle(rand_particle());
      drain_pushes();

      // Directed particles. dt of one half makes a raw velocity of one land
      // exactly on a rounding tie, which must round toward plus infinity.
      // E at both extremes and B fields of one, minus one and one half force the clamp ahead of dt.
      set_fields(32'h00008000, 32'h7FFFFFFF, 32'h80000000, 32'h00000001,
                 32'h00010000, 32'hFFFF0000, 32'h00008000);
      gap_max = 0;
      send_particle(make_particle(0, 0, 0, 0, 0, 0, 1'b0));
      send_particle(make_particle(0, 0, 0, 1, 32'hFFFFFFFF, 3, 1'b1));
      send_particle(make_particle(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                  32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0));
      send_particle(make_particle(32'h80000000, 32'h80000000, 32'h80000000,
                                  32'h80000000, 32'h80000000, 32'h80000000, 1'b1));
      send_particle(make_particle(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                                  1, 32'hFFFFFFFF, 1, 1'b0));
      send_particle(make_particle(32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                                  32'hFFFFFFFF, 1, 32'hFFFFFFFF, 1'b1));
      send_particle(make_particle(32'h55555555, 32'hAAAAAAAA, 32'hFFFFFFFF,
                                  32'hAAAAAAAA, 32'h55555555, 32'h00010000, 1'b0));
      send_particle(make_particle(32'hAAAAAAAA, 32'h55555555, 32'h00000000,
                                  32'h55555555, 32'hAAAAAAAA, 32'hFFFF0000, 1'b1));
      send_particle(make_particle(32'h00010000, 32'hFFFF0000, 32'h00008000,
                                  32'h7FFFFFFF, 32'h80000000, 32'h00000000, 1'b0));
      send_particle(make_particle(32'h00000000, 32'h00000000, 32'h00000000,
                                  32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0));
      gap_max = 14;
      for (n = 0; n < 10; n++) send_particle(rand_particle());
      drain_pushes();

      // Random phases, each with its own field setting between idle gaps.
      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0: set_fields(32'h00010000, rand_fx(), rand_fx(), rand_fx(),
                          rand_fx(), rand_fx(), rand_fx());
            1: set_fields(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                          32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
            2: set_fields(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                          32'h80000000, 32'h80000000, 32'h80000000);
            3: set_fields(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h00000000,
                          32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF);
            4: set_fields(32'h00008000, 32'h00000000, 32'h00000000, 32'h00000000,
                          $urandom(), $urandom(), $urandom());
            5: set_fields(32'h00000001, $urandom(), $urandom(), $urandom(),
                          32'h00010000, 32'h00010000, 32'h00010000);
            default: set_fields(rand_fx(), rand_fx(), rand_fx(), rand_fx(),
                                rand_fx(), rand_fx(), rand_fx());
         endcase
         for (n = 0; n < 235; n++) begin
            // New idling stretch every 32 particles; about a third of the
            // stretches run with a transfer on every cycle.
            if (n % 32 == 0) gap_max = ($urandom_range(0, 2) == 0) ? 0 : 14;
            send_particle(rand_particle());
            if ($urandom_range(0, 79) == 0) drain_pushes();
         end
         drain_pushes();
      end

      if (sb.errors == 0) begin
         $display("lorentz_particle_push regression: pass");
      end else begin
         $display("lorentz_particle_push regression: fail");
      end
      $finish;
   end

endmodule
